>>> hdl/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants of the lru key-value cache with expiry.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int TIME_BITS  = 32;
    localparam int TTL_BITS   = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_DELETED = 3'd3;
    localparam logic [2:0] ST_TICKED  = 3'd4;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  has_exp;
        logic [TIME_BITS-1:0]  exp_time;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SHIFT,
        CMD_CLEAR
    } cell_cmd_t;

    typedef struct packed {
        entry_t               front;
        logic [KEY_BITS-1:0]  key;
        logic [TIME_BITS-1:0] now;
    } chain_ctl_t;

endpackage

>>> hdl/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell
// One entry of the recency chain: holds, takes its neighbour's entry or clears.
// ----------------------------------------------------------------------------
module lkc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkc_pkg::cell_cmd_t            cmd,
    input  lkc_pkg::entry_t               prev,
    input  logic [lkc_pkg::KEY_BITS-1:0]  key,
    input  logic [lkc_pkg::TIME_BITS-1:0] now,
    output lkc_pkg::entry_t               entry,
    output logic                          hit,
    output logic                          expired
);

    logic                          valid_reg;
    logic                          has_exp_reg;
    logic [lkc_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkc_pkg::VALUE_BITS-1:0] value_reg;
    logic [lkc_pkg::TIME_BITS-1:0]  exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            has_exp_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                lkc_pkg::CMD_SHIFT:
                begin
                    valid_reg   <= prev.valid;
                    has_exp_reg <= prev.has_exp;
                end
                lkc_pkg::CMD_CLEAR:
                begin
                    valid_reg   <= 1'b0;
                    has_exp_reg <= 1'b0;
                end
                default:
                begin
                    valid_reg   <= valid_reg;
                    has_exp_reg <= has_exp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == lkc_pkg::CMD_SHIFT)
        begin
            key_reg   <= prev.key;
            value_reg <= prev.value;
            exp_reg   <= prev.exp_time;
        end
    end

    assign entry   = '{valid: valid_reg, key: key_reg, value: value_reg,
                       has_exp: has_exp_reg, exp_time: exp_reg};
    assign hit     = valid_reg && (key_reg == key);
    assign expired = valid_reg && has_exp_reg && (now >= exp_reg);

endmodule

>>> hdl/lkc_chain.sv
// ----------------------------------------------------------------------------
// lkc_chain
// Entry cells, most recent first; cell 0 fed by ctl, the rest by a neighbour.
// ----------------------------------------------------------------------------
module lkc_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkc_pkg::chain_ctl_t          ctl,
    input  lkc_pkg::cell_cmd_t           cmd     [lkc_pkg::ENTRIES],
    output lkc_pkg::entry_t              entries [lkc_pkg::ENTRIES],
    output logic [lkc_pkg::ENTRIES-1:0]  hit_vec,
    output logic [lkc_pkg::ENTRIES-1:0]  exp_vec
);

    genvar g;
    generate
        for (g = 0; g < lkc_pkg::ENTRIES; g++)
        begin : g_cell
            lkc_pkg::entry_t prev;
            if (g == 0)
            begin : g_front
                assign prev = ctl.front;
            end
            else
            begin : g_link
                assign prev = entries[g-1];
            end
            lkc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd[g]),
                .prev    (prev),
                .key     (ctl.key),
                .now     (ctl.now),
                .entry   (entries[g]),
                .hit     (hit_vec[g]),
                .expired (exp_vec[g])
            );
        end
    endgenerate

endmodule

>>> hdl/lru_key_value_cache_with_expiry_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_with_expiry_top
// LRU key-value cache with per-key expiry built on a chain of entry cells.
// ----------------------------------------------------------------------------
// channel  dir  handshake              contents
// s_*      in   s_tvalid / s_tready    tuser: opcode; tdata: key, value, has_ttl, ttl
// m_*      out  m_tvalid / m_tready    tuser: status; tdata: read_value, evicted, count
// apb      in   psel, penable, pready  reg 0 at 0x0: capacity_limit
//
// a word is accepted and then executed; a set of a new key at the limit stays
// in execute, the eviction loop removing the least recent entry per cycle.
// reset empties every cell and clears the clock; the limit returns to 5.
// a new word is taken in idle once the result register is free or drains that cycle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_with_expiry_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic [87:0] s_tdata,   // [31:0] key, [63:32] value, [64] has_ttl,
                                   // [80:65] ttl_seconds, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic [39:0] m_tdata,   // [31:0] read_value, [32] evicted,
                                   // [36:33] removed_count, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    localparam int E = lkc_pkg::ENTRIES;
    localparam int IW = lkc_pkg::IDX_W;
    localparam int CW = lkc_pkg::CNT_W;
    localparam logic [lkc_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    state_t                          state_reg;
    logic [lkc_pkg::CAP_W-1:0]       cap_reg;
    logic [CW-1:0]                   live_reg, live_next;
    logic [lkc_pkg::TIME_BITS-1:0]   now_reg, now_next;
    logic                            ev_reg, ev_next;
    logic [1:0]                      op_reg;
    logic [lkc_pkg::KEY_BITS-1:0]    key_reg;
    logic [lkc_pkg::VALUE_BITS-1:0]  val_reg;
    logic                            ttl_on_reg;
    logic [lkc_pkg::TTL_BITS-1:0]    ttl_reg;

    logic                            out_valid_reg;
    logic [2:0]                      out_status_reg;
    logic [lkc_pkg::VALUE_BITS-1:0]  out_value_reg;
    logic                            out_ev_reg;
    logic [CW-1:0]                   out_cnt_reg;

    lkc_pkg::chain_ctl_t             ctl;
    lkc_pkg::cell_cmd_t              cmd [E];
    lkc_pkg::entry_t                 entries [E];
    logic [E-1:0]                    hit_vec, exp_vec, clear_vec;

    logic                            accept, finish, do_shift, hit_any;
    logic [IW-1:0]                   hit_idx, free_idx, last_idx, stop_idx;
    logic [CW-1:0]                   cap_eff, pop;
    logic [2:0]                      status;
    logic [lkc_pkg::VALUE_BITS-1:0]  rv;
    logic [lkc_pkg::TIME_BITS:0]     exp_sum;
    logic [lkc_pkg::TIME_BITS-1:0]   exp_t, now_sat;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {{(32-lkc_pkg::CAP_W){1'b0}}, cap_reg};
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'd0, out_cnt_reg, out_ev_reg, out_value_reg};

    // limit of zero acts as one, above the row acts as the row
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CW'(1);
        else if (32'(cap_reg) > E)
            cap_eff = CW'(E);
        else
            cap_eff = CW'(cap_reg);
    end

    assign now_sat = (now_reg == TIME_MAX) ? now_reg : now_reg + 1'b1;
    assign exp_sum = {1'b0, now_reg} + {{(lkc_pkg::TIME_BITS+1-lkc_pkg::TTL_BITS){1'b0}}, ttl_reg};
    assign exp_t   = exp_sum[lkc_pkg::TIME_BITS] ? TIME_MAX
                                                 : exp_sum[lkc_pkg::TIME_BITS-1:0];

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        last_idx = '0;
        pop      = '0;
        for (int i = E - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!entries[i].valid)
                free_idx = IW'(i);
        end
        for (int i = 0; i < E; i++)
        begin
            if (entries[i].valid)
                last_idx = IW'(i);
            pop = pop + CW'(exp_vec[i]);
        end
    end

    always_comb
    begin
        ctl.key   = key_reg;
        ctl.now   = (op_reg == lkc_pkg::OP_TICK) ? now_sat : now_reg;
        ctl.front = '{valid: 1'b1, key: key_reg, value: val_reg,
                      has_exp: ttl_on_reg, exp_time: exp_t};
        finish    = 1'b1;
        do_shift  = 1'b0;
        stop_idx  = '0;
        clear_vec = '0;
        live_next = live_reg;
        now_next  = now_reg;
        ev_next   = ev_reg;
        status    = lkc_pkg::ST_STORED;
        rv        = '0;
        case (op_reg)
            lkc_pkg::OP_SET:
            begin
                if (hit_any)
                begin
                    do_shift = 1'b1;
                    stop_idx = hit_idx;
                end
                else if (live_reg >= cap_eff)
                begin
                    clear_vec[last_idx] = 1'b1;
                    live_next = live_reg - 1'b1;
                    ev_next   = 1'b1;
                    finish    = 1'b0;
                end
                else
                begin
                    do_shift  = 1'b1;
                    stop_idx  = free_idx;
                    live_next = live_reg + 1'b1;
                end
            end
            lkc_pkg::OP_GET:
            begin
                status = lkc_pkg::ST_MISS;
                if (hit_any && exp_vec[hit_idx])
                begin
                    clear_vec[hit_idx] = 1'b1;
                    live_next = live_reg - 1'b1;
                end
                else if (hit_any)
                begin
                    ctl.front = entries[hit_idx];
                    do_shift  = 1'b1;
                    stop_idx  = hit_idx;
                    rv        = entries[hit_idx].value;
                    status    = lkc_pkg::ST_HIT;
                end
            end
            lkc_pkg::OP_DEL:
            begin
                status = lkc_pkg::ST_DELETED;
                if (hit_any)
                begin
                    clear_vec[hit_idx] = 1'b1;
                    live_next = live_reg - 1'b1;
                end
            end
            default:
            begin
                status    = lkc_pkg::ST_TICKED;
                now_next  = now_sat;
                clear_vec = exp_vec;
                live_next = live_reg - pop;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < E; i++)
        begin
            if (state_reg != S_EXEC)
                cmd[i] = lkc_pkg::CMD_HOLD;
            else if (clear_vec[i])
                cmd[i] = lkc_pkg::CMD_CLEAR;
            else if (do_shift && (i <= int'(stop_idx)))
                cmd[i] = lkc_pkg::CMD_SHIFT;
            else
                cmd[i] = lkc_pkg::CMD_HOLD;
        end
    end

    lkc_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .cmd     (cmd),
        .entries (entries),
        .hit_vec (hit_vec),
        .exp_vec (exp_vec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= lkc_pkg::CAP_RESET;
            live_reg      <= '0;
            now_reg       <= '0;
            ev_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && !paddr[2])
                cap_reg <= pwdata[lkc_pkg::CAP_W-1:0];
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ev_reg    <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    live_reg <= live_next;
                    now_reg  <= now_next;
                    ev_reg   <= ev_next;
                    if (finish)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[31:0];
            val_reg    <= s_tdata[63:32];
            ttl_on_reg <= s_tdata[64];
            ttl_reg    <= s_tdata[80:65];
        end
        if ((state_reg == S_EXEC) && finish)
        begin
            out_status_reg <= status;
            out_value_reg  <= rv;
            out_ev_reg     <= ev_next;
            out_cnt_reg    <= (op_reg == lkc_pkg::OP_TICK) ? pop : '0;
        end
    end

endmodule

>>> tb/sv/lru_key_value_cache_with_expiry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_with_expiry_checker
// Watches the request, response and register channels of the cache, keeps
// its own copy of the table, recency ranks, live count and clock, and
// compares every response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_key_value_cache_with_expiry_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [2:0]  m_tuser,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    localparam int QDEPTH = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic        evicted;
        logic [3:0]  removed_count;
    } cache_resp_t;

    logic                           slot_valid [lkc_pkg::ENTRIES];
    logic [lkc_pkg::KEY_BITS-1:0]   slot_key   [lkc_pkg::ENTRIES];
    logic [lkc_pkg::VALUE_BITS-1:0] slot_value [lkc_pkg::ENTRIES];
    logic                           slot_has_exp [lkc_pkg::ENTRIES];
    logic [lkc_pkg::TIME_BITS-1:0]  slot_exp   [lkc_pkg::ENTRIES];
    int unsigned                    slot_rank  [lkc_pkg::ENTRIES];
    int unsigned                    live_keys;
    logic [lkc_pkg::TIME_BITS-1:0]  clock_secs;
    logic [lkc_pkg::CAP_W-1:0]      cap_reg;

    cache_resp_t resp_fifo [QDEPTH];
    logic [3:0]  wr_ptr;
    logic [3:0]  rd_ptr;
    int          fill;

    assign pending = fill;

    function automatic int lookup(logic [lkc_pkg::KEY_BITS-1:0] k);
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void make_recent(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void remove_slot(int s);
        int unsigned r;
        r = slot_rank[s];
        slot_valid[s] = 1'b0;
        slot_has_exp[s] = 1'b0;
        slot_rank[s] = 0;
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] > r)
                slot_rank[i]--;
        if (live_keys > 0)
            live_keys--;
    endfunction

    function automatic bit has_expired(int s);
        return slot_has_exp[s] && clock_secs >= slot_exp[s];
    endfunction

    function automatic bit evict_oldest();
        int victim;
        int unsigned worst;
        victim = -1;
        worst = 0;
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (slot_valid[i] && (victim < 0 || slot_rank[i] >= worst))
            begin
                victim = i;
                worst = slot_rank[i];
            end
        if (victim < 0)
            return 1'b0;
        remove_slot(victim);
        return 1'b1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            if (!slot_valid[i])
                return i;
        return -1;
    endfunction

    function automatic cache_resp_t cache_access(logic [1:0] op,
                                                 logic [lkc_pkg::KEY_BITS-1:0] k,
                                                 logic [lkc_pkg::VALUE_BITS-1:0] v,
                                                 logic ht,
                                                 logic [lkc_pkg::TTL_BITS-1:0] ttl);
        cache_resp_t r;
        int unsigned lim;
        int s;
        logic [lkc_pkg::TIME_BITS:0] sum;
        r = '0;
        lim = 32'(cap_reg);
        if (lim < 1)
            lim = 1;
        if (lim > lkc_pkg::ENTRIES)
            lim = lkc_pkg::ENTRIES;
        s = lookup(k);
        case (op)
            lkc_pkg::OP_SET:
            begin
                if (s < 0)
                begin
                    while (live_keys >= lim && evict_oldest())
                        r.evicted = 1'b1;
                    s = free_slot();
                    if (s < 0)
                    begin
                        void'(evict_oldest());
                        r.evicted = 1'b1;
                        s = free_slot();
                    end
                    for (int i = 0; i < lkc_pkg::ENTRIES; i++)
                        if (slot_valid[i])
                            slot_rank[i]++;
                    slot_valid[s] = 1'b1;
                    slot_key[s] = k;
                    slot_rank[s] = 0;
                    live_keys++;
                end
                slot_value[s] = v;
                slot_has_exp[s] = ht;
                if (ht)
                begin
                    // expiry time saturates at the top of the clock range
                    sum = {1'b0, clock_secs}
                        + {{(lkc_pkg::TIME_BITS+1-lkc_pkg::TTL_BITS){1'b0}}, ttl};
                    slot_exp[s] = sum[lkc_pkg::TIME_BITS] ? '1
                                                          : sum[lkc_pkg::TIME_BITS-1:0];
                end
                make_recent(s);
                r.status = lkc_pkg::ST_STORED;
            end
            lkc_pkg::OP_GET:
            begin
                r.status = lkc_pkg::ST_MISS;
                if (s >= 0)
                begin
                    if (has_expired(s))
                        remove_slot(s);
                    else
                    begin
                        r.read_value = slot_value[s];
                        make_recent(s);
                        r.status = lkc_pkg::ST_HIT;
                    end
                end
            end
            lkc_pkg::OP_DEL:
            begin
                if (s >= 0)
                    remove_slot(s);
                r.status = lkc_pkg::ST_DELETED;
            end
            default:
            begin
                if (clock_secs != '1)
                    clock_secs++;
                for (int i = 0; i < lkc_pkg::ENTRIES; i++)
                    if (slot_valid[i] && has_expired(i))
                    begin
                        remove_slot(i);
                        r.removed_count++;
                    end
                r.status = lkc_pkg::ST_TICKED;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lkc_pkg::ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_has_exp[i] = 1'b0;
                slot_exp[i] = '0;
                slot_rank[i] = 0;
            end
            live_keys = 0;
            clock_secs = '0;
            cap_reg = lkc_pkg::CAP_RESET;
            wr_ptr = '0;
            rd_ptr = '0;
            fill = 0;
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                cap_reg = pwdata[lkc_pkg::CAP_W-1:0];
            if (s_tvalid && s_tready)
            begin
                if (fill == QDEPTH)
                begin
                    $error("prediction store overflow");
                    fail_count++;
                end
                else
                begin
                    resp_fifo[wr_ptr] = cache_access(s_tuser, s_tdata[31:0],
                        s_tdata[63:32], s_tdata[64], s_tdata[80:65]);
                    wr_ptr = wr_ptr + 1'b1;
                    fill++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (fill == 0)
                begin
                    $error("response word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    cache_resp_t e;
                    e = resp_fifo[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    fill--;
                    if (m_tuser !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== e.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               e.read_value, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[32] !== e.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", e.evicted, m_tdata[32]);
                        fail_count++;
                    end
                    if (m_tdata[36:33] !== e.removed_count)
                    begin
                        $error("removed_count: expected %0d, got %0d",
                               e.removed_count, m_tdata[36:33]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/lru_key_value_cache_with_expiry_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_with_expiry_top_tb
// Drives set, get, delete and tick words into the cache under several
// capacity limits and idling patterns; a separate checker predicts and
// compares every response word.
// ----------------------------------------------------------------------------
module lru_key_value_cache_with_expiry_top_tb;

    localparam int CHUNK_WORDS = 242;
    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [2:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int src_idle = 35;
    int snk_idle = 83;
    int stall_cycles = 0;
    logic [31:0] key_pool [16];

    lru_key_value_cache_with_expiry_top dut (.*);

    lru_key_value_cache_with_expiry_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[lru_key_value_cache_with_expiry_top] ERROR");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                             logic ht, logic [15:0] ttl);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, ttl, ht, v, k};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the sender until every response has drained and the block is quiet
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [31:0] lim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= lim;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word;
        logic [1:0]  op;
        logic [31:0] k;
        logic [15:0] ttl;
        int pick;
        pick = $urandom_range(99);
        op = pick < 35 ? lkc_pkg::OP_SET : pick < 70 ? lkc_pkg::OP_GET :
             pick < 80 ? lkc_pkg::OP_DEL : lkc_pkg::OP_TICK;
        k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
        ttl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
        send_word(op, k, $urandom, 1'($urandom_range(1)), ttl);
    endtask

    initial
    begin
        int limits [6];
        limits = '{8, 1, 0, 15, 3, 5};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 16; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes, zero lifetime, expiry on get and tick,
        // overwrite, absent delete, eviction at the reset limit
        send_word(lkc_pkg::OP_GET,  32'h0, 32'h0, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_SET,  32'h0, 32'hffff_ffff, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_GET,  32'h0, 32'h0, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_SET,  32'hffff_ffff, 32'h0, 1'b1, 16'h0);
        send_word(lkc_pkg::OP_GET,  32'hffff_ffff, 32'h0, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_SET,  32'hffff_ffff, 32'h5a5a_a5a5, 1'b1, 16'hffff);
        send_word(lkc_pkg::OP_SET,  32'h0, 32'h1234_5678, 1'b1, 16'h1);
        send_word(lkc_pkg::OP_TICK, 32'h0, 32'h0, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_DEL,  32'h5, 32'h0, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_DEL,  32'hffff_ffff, 32'h0, 1'b0, 16'h0);
        for (int i = 1; i <= 6; i++)
            send_word(lkc_pkg::OP_SET, i, 32'h100 + i, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_GET,  32'h1, 32'h0, 1'b0, 16'h0);
        drain();
        write_limit(8);
        for (int i = 7; i <= 9; i++)
            send_word(lkc_pkg::OP_SET, i, 32'h200 + i, 1'b1, 16'h3);
        drain();
        // limit lowered below the live count: next new key evicts several
        write_limit(2);
        send_word(lkc_pkg::OP_SET,  32'd100, 32'hdead_beef, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_SET,  32'd200, 32'h1, 1'b1, 16'h0);
        send_word(lkc_pkg::OP_SET,  32'd200, 32'h2, 1'b0, 16'h0);
        send_word(lkc_pkg::OP_GET,  32'd200, 32'h0, 1'b0, 16'h0);
        drain();

        for (int c = 0; c < 6; c++)
        begin
            write_limit(limits[c]);
            src_idle = c < 2 ? 35 : c < 4 ? 83 : 0;
            snk_idle = c < 2 ? 83 : c < 4 ? 35 : 0;
            for (int n = 0; n < CHUNK_WORDS; n++)
                random_word();
            drain();
        end

        if (fail_count == 0)
            $display("[lru_key_value_cache_with_expiry_top] OK");
        else
            $display("[lru_key_value_cache_with_expiry_top] ERROR");
        $finish;
    end

endmodule
